>>> rtl/core/rms_sound_level_meter_defines.svh
// Assertion macros shared by the RMS level meter RTL
`ifndef RMS_SOUND_LEVEL_METER_DEFINES_SVH
`define RMS_SOUND_LEVEL_METER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RMSLM_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RMSLM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rmslm_pkg.sv
// Shared constants, register indexes and result type of the RMS level meter
`timescale 1ns / 1ps
package rmslm_pkg;

  localparam int unsigned SAMPLE_BITS   = 12;
  localparam int unsigned CENTER_BITS   = 12;
  localparam int unsigned STEP_BITS     = 13;
  localparam int unsigned MAG_BITS      = 13;
  localparam int unsigned LEVEL_BITS    = 3;
  localparam int unsigned WLOG_BITS     = 5;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam int unsigned CFG_IDX_BITS  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LOG2 = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_CODE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_STEP  = 2'd2;

  // Register reset values
  localparam logic [WLOG_BITS-1:0]   WLOG_RESET   = 5'd10;
  localparam logic [CENTER_BITS-1:0] CENTER_RESET = 12'd2048;
  localparam logic [STEP_BITS-1:0]   STEP_RESET   = 13'd64;

  // Highest reported intensity; a raw count above it sets the clip flag
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 3'd4;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] rms_code;
    logic [MAG_BITS-1:0]    magnitude;
    logic [LEVEL_BITS-1:0]  intensity;
    logic                   level_clipped;
  } rmslm_result_t;

endpackage

>>> rtl/core/rmslm_if.sv
// Valid/ready channel interfaces for samples and level results
`timescale 1ns / 1ps
interface rmslm_sample_if;
  import rmslm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmslm_result_if;
  import rmslm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] rms_code;
  logic [MAG_BITS-1:0]    magnitude;
  logic [LEVEL_BITS-1:0]  intensity;
  logic                   level_clipped;

  modport source (output valid, output rms_code, output magnitude, output intensity,
                  output level_clipped, input ready);
  modport sink (input valid, input rms_code, input magnitude, input intensity,
                input level_clipped, output ready);
endinterface

>>> rtl/core/rms_sound_level_meter.sv
// RMS sound level meter: one sample per cycle in while idle, one level result per window.
// A window's last sample starts a run: a load, one root bit per cycle on the shared
// subtractor, the absolute difference (with a negate step when the root is below the
// center), one to five level steps and a done state, which also waits while the
// previous result is unread; input is not ready meanwhile.
// rst_ni clears the sum, the count, the sequencer and loads the register defaults.
`timescale 1ns / 1ps
module rms_sound_level_meter #(
  parameter int unsigned MAX_WINDOW_LOG2 = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rmslm_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [rmslm_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  rmslm_sample_if.sink                        in_if,
  rmslm_result_if.source                      out_if
);
  import rmslm_pkg::*;

  localparam int unsigned SumBits = 2 * SAMPLE_BITS + MAX_WINDOW_LOG2;

  logic [WLOG_BITS-1:0]   wlog_q;
  logic [CENTER_BITS-1:0] center_q;
  logic [STEP_BITS-1:0]   step_q;
  logic [WLOG_BITS-1:0]   wlog_eff;
  logic [STEP_BITS-1:0]   step_eff;

  logic               in_transfer;
  logic               last;
  logic               clear;
  logic               ready;
  logic [SumBits-1:0] mean;
  rmslm_result_t      result;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlog_q   <= WLOG_RESET;
      center_q <= CENTER_RESET;
      step_q   <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LOG2: wlog_q   <= cfg_data_i[WLOG_BITS-1:0];
        REG_CENTER_CODE: center_q <= cfg_data_i[CENTER_BITS-1:0];
        REG_LEVEL_STEP:  step_q   <= cfg_data_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp window size and step to usable values
  always_comb begin
    priority if (wlog_q == '0) begin
      wlog_eff = WLOG_BITS'(1);
    end else if (wlog_q > WLOG_BITS'(MAX_WINDOW_LOG2)) begin
      wlog_eff = WLOG_BITS'(MAX_WINDOW_LOG2);
    end else begin
      wlog_eff = wlog_q;
    end
  end

  assign step_eff = (step_q == '0) ? STEP_BITS'(1) : step_q;

  assign in_transfer = in_if.valid && ready;
  assign in_if.ready = ready;

  rmslm_accum #(
    .MAX_WINDOW_LOG2(MAX_WINDOW_LOG2),
    .SumBits        (SumBits)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (in_transfer),
    .sample_i  (in_if.sample),
    .clear_i   (clear),
    .win_log2_i(wlog_eff),
    .last_o    (last),
    .mean_o    (mean)
  );

  rmslm_seq #(
    .SumBits(SumBits)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_transfer && last),
    .mean_i     (mean),
    .center_i   (center_q),
    .step_i     (step_eff),
    .clear_o    (clear),
    .in_ready_o (ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .result_o   (result)
  );

  assign out_if.rms_code      = result.rms_code;
  assign out_if.magnitude     = result.magnitude;
  assign out_if.intensity     = result.intensity;
  assign out_if.level_clipped = result.level_clipped;

endmodule

>>> rtl/core/rmslm_alu.sv
// Shared subtract/compare unit used by the root, absolute-difference and level steps of the sequencer
`timescale 1ns / 1ps
module rmslm_alu #(
  parameter int unsigned Width = 40
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] diff_o,
  output logic             borrow_o
);

  // borrow set means a < b
  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

>>> rtl/core/rmslm_accum.sv
// Sum-of-squares accumulator with window counter and mean shifter
`timescale 1ns / 1ps
module rmslm_accum #(
  parameter int unsigned MAX_WINDOW_LOG2 = 16,
  parameter int unsigned SumBits         = 2 * rmslm_pkg::SAMPLE_BITS + MAX_WINDOW_LOG2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               take_i,
  input  logic [rmslm_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                               clear_i,
  input  logic [rmslm_pkg::WLOG_BITS-1:0]    win_log2_i,
  output logic                               last_o,
  output logic [SumBits-1:0]                 mean_o
);
  import rmslm_pkg::*;

  localparam int unsigned CntBits = MAX_WINDOW_LOG2 + 1;

  logic [SumBits-1:0]         sum_q;
  logic [MAX_WINDOW_LOG2-1:0] count_q;
  logic [2*SAMPLE_BITS-1:0]   square;
  logic [CntBits-1:0]         cnt_inc;
  logic [CntBits-1:0]         win_size;

  assign square = sample_i * sample_i;

  // Window ends once the count including this sample reaches 2^w
  assign cnt_inc  = {1'b0, count_q} + CntBits'(1);
  assign win_size = CntBits'(1) << win_log2_i;
  assign last_o   = (cnt_inc >= win_size);

  assign mean_o = sum_q >> win_log2_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (clear_i) begin
      sum_q <= '0;
    end else if (take_i) begin
      sum_q   <= sum_q + SumBits'(square);
      count_q <= last_o ? '0 : cnt_inc[MAX_WINDOW_LOG2-1:0];
    end
  end

endmodule

>>> rtl/core/rmslm_seq.sv
// Sequencer: bit-serial square root, magnitude and level count on one shared unit
`timescale 1ns / 1ps
`include "rms_sound_level_meter_defines.svh"
module rmslm_seq #(
  parameter int unsigned SumBits = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [SumBits-1:0]                mean_i,
  input  logic [rmslm_pkg::CENTER_BITS-1:0] center_i,
  input  logic [rmslm_pkg::STEP_BITS-1:0]   step_i,
  output logic                              clear_o,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rmslm_pkg::rmslm_result_t          result_o
);
  import rmslm_pkg::*;

  localparam int unsigned RootBits = (SumBits + 1) / 2;
  localparam int unsigned RemBits  = RootBits + 1;
  localparam logic [SumBits-1:0] BitInit = SumBits'(1) << (2 * (RootBits - 1));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_SQRT  = 3'd2;
  localparam logic [2:0] ST_ABS   = 3'd3;
  localparam logic [2:0] ST_NEG   = 3'd4;
  localparam logic [2:0] ST_LEVEL = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [SumBits-1:0]    v_q, v_d;
  logic [SumBits-1:0]    res_q, res_d;
  logic [SumBits-1:0]    bit_q, bit_d;
  logic [RemBits-1:0]    rem_q, rem_d;
  logic [RemBits-1:0]    mag_q, mag_d;
  logic [LEVEL_BITS-1:0] cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  rmslm_result_t         out_q, out_d;

  logic [SumBits-1:0] alu_a, alu_b, alu_diff;
  logic               alu_borrow;
  logic               alu_gt;
  logic               out_free;

  // Operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      ST_SQRT: begin
        alu_a = v_q;
        alu_b = res_q | bit_q;
      end
      ST_ABS: begin
        alu_a = res_q;
        alu_b = SumBits'(center_i);
      end
      ST_NEG: begin
        alu_a = SumBits'(center_i);
        alu_b = res_q;
      end
      ST_LEVEL: begin
        alu_a = SumBits'(rem_q);
        alu_b = SumBits'(step_i);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  rmslm_alu #(
    .Width(SumBits)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .diff_o  (alu_diff),
    .borrow_o(alu_borrow)
  );

  assign alu_gt   = !alu_borrow && (alu_diff != '0);
  assign out_free = !out_valid_q || out_ready_i;

  // Step sequencing
  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    res_d       = res_q;
    bit_d       = bit_q;
    rem_d       = rem_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        v_d     = mean_i;
        res_d   = '0;
        bit_d   = BitInit;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        // one root bit per cycle; res never overlaps bit, so OR acts as add
        if (!alu_borrow) begin
          v_d   = alu_diff;
          res_d = (res_q >> 1) | bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[1:0] != 2'b00) state_d = ST_ABS;
      end
      ST_ABS: begin
        if (alu_borrow) begin
          state_d = ST_NEG;
        end else begin
          mag_d   = {alu_diff[RootBits-1:0], 1'b0};
          rem_d   = {alu_diff[RootBits-1:0], 1'b0};
          cnt_d   = '0;
          state_d = ST_LEVEL;
        end
      end
      ST_NEG: begin
        mag_d   = {alu_diff[RootBits-1:0], 1'b0};
        rem_d   = {alu_diff[RootBits-1:0], 1'b0};
        cnt_d   = '0;
        state_d = ST_LEVEL;
      end
      ST_LEVEL: begin
        // count steps strictly below the magnitude, stop one past the top level
        if (alu_gt) begin
          rem_d = alu_diff[RemBits-1:0];
          cnt_d = cnt_q + LEVEL_BITS'(1);
          if (cnt_q == LEVEL_MAX) state_d = ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.rms_code      = res_q[SAMPLE_BITS-1:0];
          out_d.magnitude     = mag_q[MAG_BITS-1:0];
          out_d.intensity     = (cnt_q > LEVEL_MAX) ? LEVEL_MAX : cnt_q;
          out_d.level_clipped = (cnt_q > LEVEL_MAX);
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
    mag_q <= mag_d;
    out_q <= out_d;
  end

  assign clear_o     = (state_q == ST_LOAD);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  `RMSLM_ASSERT_NEXT(a_done_sets_valid, clk_i, rst_ni, (state_q == ST_DONE) && out_free, out_valid_q, "result not presented after done")
  `RMSLM_ASSERT_IMPL(a_clip_saturates, clk_i, rst_ni, out_valid_q && out_q.level_clipped, out_q.intensity == LEVEL_MAX, "clip without saturated intensity")
  `RMSLM_ASSERT_IMPL(a_sqrt_bit_onehot, clk_i, rst_ni, state_q == ST_SQRT, $onehot(bit_q), "square root bit lost")
  `RMSLM_ASSERT_IMPL(a_rem_bounded, clk_i, rst_ni, state_q == ST_LEVEL, rem_q <= mag_q, "level remainder above magnitude")

endmodule
